// ----- hw/rtl/hvd_pkg.sv -----
// Haversine distance pipeline: shared constants, CORDIC arctangent table, cell data types.
// No dependencies.
`timescale 1ns / 1ps

package hvd_pkg;

    // CORDIC, divider and square root geometry
    localparam int ANGLE_STEPS = 32;
    localparam int STEP_W      = $clog2(ANGLE_STEPS);
    localparam int MAG_WIDTH   = 26;
    localparam int DIV_STAGES  = 3;
    localparam int SQRT_STEPS  = 31;
    localparam int RAD_WIDTH   = 2 * SQRT_STEPS;
    localparam int REM_WIDTH   = 34;
    localparam int VEC_WIDTH   = 49;

    // input reg, divider, fold, rotation, sign fix, three multiplies,
    // sum/clamp, complement, square root, vectoring, three output stages
    localparam int LATENCY = 1 + DIV_STAGES + 1 + ANGLE_STEPS + 1 + 3 + 2
                             + SQRT_STEPS + ANGLE_STEPS + 3;

    localparam logic [6:0]         DIVISOR      = 7'd45;
    localparam logic [5:0]         ROUND_BIAS   = 6'd22;
    // ceil(2^32 / 45): exact floor(m / 45) for m < 2^26
    localparam logic [26:0]        RECIP_45     = 27'd95443718;
    // ceil(2^24 / 45): exact floor(n / 45) for the remainder term n < 2^18
    localparam logic [18:0]        RECIP_FRAC   = 19'd372828;
    localparam logic signed [32:0] INV_GAIN_Q30 = 33'sd652032874;
    localparam logic [30:0]        PI_Q29       = 31'd1686629713;
    localparam logic [25:0]        DIST_MAX     = 26'd52706125;
    localparam logic [15:0]        RADIUS_RESET = 16'd6378;

    // atan(2^-i) in binary angle, 2^32 per turn
    localparam logic [31:0] ATAN_TABLE [ANGLE_STEPS] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
        32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
        32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
    };

    typedef struct packed {
        logic [MAG_WIDTH-1:0] mag;
        logic                 neg;
    } div_t;

    typedef struct packed {
        logic [31:0] q;
        logic        neg;
    } quo_t;

    typedef struct packed {
        logic signed [32:0] x;
        logic signed [32:0] y;
        logic signed [33:0] z;
        logic               flip;
    } rot_t;

    typedef struct packed {
        logic [RAD_WIDTH-1:0]  rad;
        logic [REM_WIDTH-1:0]  rem;
        logic [SQRT_STEPS-1:0] root;
    } sqrt_t;

    typedef struct packed {
        logic signed [VEC_WIDTH-1:0] x;
        logic signed [VEC_WIDTH-1:0] y;
        logic [31:0]                 z;
    } vec_t;

endpackage

// ----- hw/rtl/hvd_div_cell.sv -----
// Divide-by-45 unit: floor((4096*mag + 22) / 45) by reciprocal multiplies, three stages.
// Depends on hvd_pkg (div_t, quo_t, reciprocal constants).
`timescale 1ns / 1ps

module hvd_div_cell
    import hvd_pkg::*;
(
    input  logic clk,
    input  div_t din,
    output quo_t dout
);

    // mag = 45*qm + rm, so the quotient is 4096*qm + floor((4096*rm + 22) / 45);
    // the second term stays below 4096 and fills the low 12 bits
    logic [52:0] recip_prod;
    logic [20:0] qm_reg;
    logic [20:0] qm_next;
    logic [25:0] mag_reg;
    logic        neg_a_reg;
    logic [5:0]  rm_reg;
    logic [5:0]  rm_next;
    logic [19:0] qm_b_reg;
    logic        neg_b_reg;
    logic [17:0] frac_num;
    logic [36:0] frac_prod;
    quo_t        dout_reg;
    quo_t        dout_next;

    assign recip_prod = 53'(din.mag) * 53'(RECIP_45);
    assign qm_next    = recip_prod[52:32];
    assign rm_next    = 6'(mag_reg - 26'(qm_reg) * 26'(DIVISOR));
    assign frac_num   = {rm_reg, 12'b0} + 18'(ROUND_BIAS);
    assign frac_prod  = 37'(frac_num) * 37'(RECIP_FRAC);

    always_comb
    begin
        dout_next.q   = {qm_b_reg, frac_prod[35:24]};
        dout_next.neg = neg_b_reg;
    end

    always_ff @(posedge clk)
    begin
        qm_reg    <= qm_next;
        mag_reg   <= din.mag;
        neg_a_reg <= din.neg;
        rm_reg    <= rm_next;
        qm_b_reg  <= qm_reg[19:0];
        neg_b_reg <= neg_a_reg;
        dout_reg  <= dout_next;
    end

    assign dout = dout_reg;

endmodule

// ----- hw/rtl/hvd_rot_cell.sv -----
// Rotation-mode CORDIC cell: one micro-rotation per stage.
// Depends on hvd_pkg (arctangent table, rot_t).
`timescale 1ns / 1ps

module hvd_rot_cell
    import hvd_pkg::*;
(
    input  logic              clk,
    input  logic [STEP_W-1:0] step,
    input  rot_t              din,
    output rot_t              dout
);

    rot_t dout_reg;
    rot_t dout_next;
    logic signed [32:0] xs;
    logic signed [32:0] ys;
    logic signed [33:0] ang;

    assign xs  = din.x >>> step;
    assign ys  = din.y >>> step;
    assign ang = signed'({2'b00, ATAN_TABLE[step]});

    always_comb
    begin
        dout_next = din;
        if (!din.z[33])
        begin
            dout_next.x = din.x - ys;
            dout_next.y = din.y + xs;
            dout_next.z = din.z - ang;
        end
        else
        begin
            dout_next.x = din.x + ys;
            dout_next.y = din.y - xs;
            dout_next.z = din.z + ang;
        end
    end

    always_ff @(posedge clk)
    begin
        dout_reg <= dout_next;
    end

    assign dout = dout_reg;

endmodule

// ----- hw/rtl/hvd_sqrt_cell.sv -----
// Integer square root cell: one result bit per stage (restoring).
// Depends on hvd_pkg (sqrt_t).
`timescale 1ns / 1ps

module hvd_sqrt_cell
    import hvd_pkg::*;
(
    input  logic  clk,
    input  sqrt_t din,
    output sqrt_t dout
);

    sqrt_t dout_reg;
    sqrt_t dout_next;
    logic [REM_WIDTH-1:0] rem_sh;
    logic [REM_WIDTH-1:0] trial;

    assign rem_sh = {din.rem[REM_WIDTH-3:0], din.rad[RAD_WIDTH-1:RAD_WIDTH-2]};
    assign trial  = {1'b0, din.root, 2'b01};

    always_comb
    begin
        dout_next.rad = {din.rad[RAD_WIDTH-3:0], 2'b00};
        if (rem_sh >= trial)
        begin
            dout_next.rem  = rem_sh - trial;
            dout_next.root = {din.root[SQRT_STEPS-2:0], 1'b1};
        end
        else
        begin
            dout_next.rem  = rem_sh;
            dout_next.root = {din.root[SQRT_STEPS-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk)
    begin
        dout_reg <= dout_next;
    end

    assign dout = dout_reg;

endmodule

// ----- hw/rtl/hvd_vec_cell.sv -----
// Vectoring-mode CORDIC cell: drives y toward zero, accumulates angle.
// Depends on hvd_pkg (arctangent table, vec_t).
`timescale 1ns / 1ps

module hvd_vec_cell
    import hvd_pkg::*;
(
    input  logic              clk,
    input  logic [STEP_W-1:0] step,
    input  vec_t              din,
    output vec_t              dout
);

    vec_t dout_reg;
    vec_t dout_next;
    logic signed [VEC_WIDTH-1:0] xs;
    logic signed [VEC_WIDTH-1:0] ys;

    assign xs = din.x >>> step;
    assign ys = din.y >>> step;

    always_comb
    begin
        if (!din.y[VEC_WIDTH-1])
        begin
            dout_next.x = din.x + ys;
            dout_next.y = din.y - xs;
            dout_next.z = din.z + ATAN_TABLE[step];
        end
        else
        begin
            dout_next.x = din.x - ys;
            dout_next.y = din.y + xs;
            dout_next.z = din.z - ATAN_TABLE[step];
        end
    end

    always_ff @(posedge clk)
    begin
        dout_reg <= dout_next;
    end

    assign dout = dout_reg;

endmodule

// ----- hw/rtl/haversine_distance.sv -----
// Each start transfer is answered by a done strobe that carries its distance.
// Throughput: one point pair per cycle; busy is never raised and results cannot be stalled.
// Reset (rst_n low, asynchronous): in-flight items are dropped, radius returns to 6378 km.
// Pipeline: reciprocal divide-by-45 units, four rotation CORDIC chains, three multiply
// stages, two square root chains, one vectoring CORDIC chain, then radius * angle * pi.
// Depends on hvd_pkg and the four hvd_*_cell modules.
`timescale 1ns / 1ps

module haversine_distance
    import hvd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [23:0] first_latitude,
    input  logic signed [23:0] second_latitude,
    input  logic signed [24:0] first_longitude,
    input  logic signed [24:0] second_longitude,
    output logic               done,
    output logic [25:0]        distance,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [15:0]        cfg_data
);

    // Lanes through the divider and rotation chains:
    // 0 = half lat difference (sin), 1 = half lon difference (sin),
    // 2 = first latitude (cos),      3 = second latitude (cos)
    localparam int LANES = 4;

    // ------------------------------------------------------------------
    // Control: radius register and valid shift line
    // ------------------------------------------------------------------
    logic [15:0]        radius_reg;
    logic [LATENCY-1:0] vld_reg;
    logic [LATENCY-1:0] vld_next;
    logic               accept;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;
    assign accept    = start && !busy;
    assign vld_next  = {vld_reg[LATENCY-2:0], accept};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg <= RADIUS_RESET;
            vld_reg    <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
            if (cfg_valid && cfg_ready)
            begin
                radius_reg <= cfg_data;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: magnitudes for the divide by 45.
    // Half difference: round(|d| * 2^16 / 720) = floor((4096|d| + 22) / 45)
    // Latitude:        round(|v| * 2^16 / 360) = floor((4096*2|v| + 22) / 45)
    // ------------------------------------------------------------------
    logic signed [24:0] dlat;
    logic signed [25:0] dlon;
    logic [24:0]        dlat_abs;
    logic [25:0]        dlon_abs;
    logic [23:0]        lat1_abs;
    logic [23:0]        lat2_abs;
    div_t               div_in_reg [LANES];
    div_t               div_in_next [LANES];

    assign dlat = {second_latitude[23], second_latitude}
                - {first_latitude[23], first_latitude};
    assign dlon = {second_longitude[24], second_longitude}
                - {first_longitude[24], first_longitude};

    assign dlat_abs = dlat[24] ? 25'(-dlat) : 25'(dlat);
    assign dlon_abs = dlon[25] ? 26'(-dlon) : 26'(dlon);
    assign lat1_abs = first_latitude[23]  ? 24'(-first_latitude)  : 24'(first_latitude);
    assign lat2_abs = second_latitude[23] ? 24'(-second_latitude) : 24'(second_latitude);

    always_comb
    begin
        div_in_next[0].mag = {1'b0, dlat_abs};
        div_in_next[0].neg = dlat[24];
        div_in_next[1].mag = dlon_abs;
        div_in_next[1].neg = dlon[25];
        div_in_next[2].mag = {1'b0, lat1_abs, 1'b0};
        div_in_next[2].neg = first_latitude[23];
        div_in_next[3].mag = {1'b0, lat2_abs, 1'b0};
        div_in_next[3].neg = second_latitude[23];
    end

    always_ff @(posedge clk)
    begin
        div_in_reg <= div_in_next;
    end

    // ------------------------------------------------------------------
    // Dividers, then quadrant fold into the rotation chains
    // ------------------------------------------------------------------
    quo_t div_q [LANES];
    rot_t rot_w [LANES][ANGLE_STEPS+1];
    rot_t rot_in_reg  [LANES];
    rot_t rot_in_next [LANES];

    genvar l, k;
    generate
        for (l = 0; l < LANES; l++)
        begin : g_lane
            hvd_div_cell u_div (
                .clk  (clk),
                .din  (div_in_reg[l]),
                .dout (div_q[l])
            );

            // Binary angle, then a half-turn fold into [-1/4, 1/4] turn
            logic [31:0] q;
            logic [31:0] ang;
            logic        flip;
            assign q    = div_q[l].q;
            assign ang  = div_q[l].neg ? 32'(-q) : q;
            assign flip = ang[31] ^ ang[30];

            always_comb
            begin
                rot_in_next[l].x    = INV_GAIN_Q30;
                rot_in_next[l].y    = '0;
                rot_in_next[l].z    = signed'({{2{ang[30]}}, ang[30], ang[30:0]});
                rot_in_next[l].flip = flip;
            end

            assign rot_w[l][0] = rot_in_reg[l];
            for (k = 0; k < ANGLE_STEPS; k++)
            begin : g_rot
                hvd_rot_cell u_rot (
                    .clk  (clk),
                    .step (STEP_W'(k)),
                    .din  (rot_w[l][k]),
                    .dout (rot_w[l][k+1])
                );
            end
        end
    endgenerate

    always_ff @(posedge clk)
    begin
        rot_in_reg <= rot_in_next;
    end

    // ------------------------------------------------------------------
    // Undo the fold and clamp to [-1, 1] in Q30
    // ------------------------------------------------------------------
    function automatic logic signed [31:0] fix_q30(input logic signed [32:0] v,
                                                   input logic flip);
        logic signed [33:0] t;
        t = flip ? -34'(v) : 34'(v);
        if (t > 34'sd1073741824)
        begin
            return 32'sd1073741824;
        end
        else if (t < -34'sd1073741824)
        begin
            return -32'sd1073741824;
        end
        return t[31:0];
    endfunction

    logic signed [31:0] s1_reg;
    logic signed [31:0] s2_reg;
    logic signed [31:0] c1_reg;
    logic signed [31:0] c2_reg;

    always_ff @(posedge clk)
    begin
        s1_reg <= fix_q30(rot_w[0][ANGLE_STEPS].y, rot_w[0][ANGLE_STEPS].flip);
        s2_reg <= fix_q30(rot_w[1][ANGLE_STEPS].y, rot_w[1][ANGLE_STEPS].flip);
        c1_reg <= fix_q30(rot_w[2][ANGLE_STEPS].x, rot_w[2][ANGLE_STEPS].flip);
        c2_reg <= fix_q30(rot_w[3][ANGLE_STEPS].x, rot_w[3][ANGLE_STEPS].flip);
    end

    // ------------------------------------------------------------------
    // a = s1^2 + (((c1*c2)>>30 * s2)>>30) * s2, one chain multiply per stage, s1^2 beside the first
    // ------------------------------------------------------------------
    logic signed [63:0] sq_reg;
    logic signed [63:0] sq_d2_reg;
    logic signed [63:0] sq_d3_reg;
    logic signed [63:0] cc_reg;
    logic signed [63:0] m2_reg;
    logic signed [63:0] m3_reg;
    logic signed [31:0] s2_d1_reg;
    logic signed [31:0] s2_d2_reg;
    logic signed [31:0] p30;
    logic signed [31:0] t30;

    assign p30 = cc_reg[61:30];
    assign t30 = m2_reg[61:30];

    always_ff @(posedge clk)
    begin
        sq_reg    <= s1_reg * s1_reg;
        cc_reg    <= c1_reg * c2_reg;
        s2_d1_reg <= s2_reg;
        m2_reg    <= p30 * s2_d1_reg;
        s2_d2_reg <= s2_d1_reg;
        sq_d2_reg <= sq_reg;
        m3_reg    <= t30 * s2_d2_reg;
        sq_d3_reg <= sq_d2_reg;
    end

    // Sum, clamp to [0, 2^60], then the complement 2^60 - a
    logic signed [63:0] a_sum;
    logic [60:0]        a_reg;
    logic [60:0]        a_next;
    logic [60:0]        ra_reg;
    logic [60:0]        rb_reg;

    assign a_sum = sq_d3_reg + m3_reg;

    always_comb
    begin
        if (a_sum < 0)
        begin
            a_next = '0;
        end
        else if (a_sum > 64'sh1000_0000_0000_0000)
        begin
            a_next = 61'h1000_0000_0000_0000;
        end
        else
        begin
            a_next = a_sum[60:0];
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg  <= a_next;
        ra_reg <= a_reg;
        rb_reg <= 61'h1000_0000_0000_0000 - a_reg;
    end

    // ------------------------------------------------------------------
    // Square roots: lane A gives sqrt(a), lane B gives sqrt(1 - a)
    // ------------------------------------------------------------------
    sqrt_t sqa_w [SQRT_STEPS+1];
    sqrt_t sqb_w [SQRT_STEPS+1];
    vec_t  vec_w [ANGLE_STEPS+1];

    assign sqa_w[0] = '{rad: {1'b0, ra_reg}, rem: '0, root: '0};
    assign sqb_w[0] = '{rad: {1'b0, rb_reg}, rem: '0, root: '0};

    generate
        for (k = 0; k < SQRT_STEPS; k++)
        begin : g_sqrt
            hvd_sqrt_cell u_sqa (
                .clk  (clk),
                .din  (sqa_w[k]),
                .dout (sqa_w[k+1])
            );
            hvd_sqrt_cell u_sqb (
                .clk  (clk),
                .din  (sqb_w[k]),
                .dout (sqb_w[k+1])
            );
        end
    endgenerate

    // Half central angle = atan2(sqrt(a), sqrt(1-a)), operands scaled by 2^16
    assign vec_w[0].x = signed'({2'b00, sqb_w[SQRT_STEPS].root, 16'b0});
    assign vec_w[0].y = signed'({2'b00, sqa_w[SQRT_STEPS].root, 16'b0});
    assign vec_w[0].z = '0;

    generate
        for (k = 0; k < ANGLE_STEPS; k++)
        begin : g_vec
            hvd_vec_cell u_vec (
                .clk  (clk),
                .step (STEP_W'(k)),
                .din  (vec_w[k]),
                .dout (vec_w[k+1])
            );
        end
    endgenerate

    // ------------------------------------------------------------------
    // distance = round(R * z * pi / 2^22), split as R*z = hi*2^23 + lo
    // ------------------------------------------------------------------
    logic [31:0] zv;
    logic [30:0] zc;
    logic [46:0] prod_reg;
    logic [54:0] hp_reg;
    logic [53:0] lp_reg;
    logic [55:0] dsum;
    logic [27:0] dfull;
    logic [25:0] dist_reg;

    assign zv = vec_w[ANGLE_STEPS].z;

    always_comb
    begin
        if (zv[31])
        begin
            zc = '0;
        end
        else if (zv > 32'h4000_0000)
        begin
            zc = 31'h4000_0000;
        end
        else
        begin
            zc = zv[30:0];
        end
    end

    assign dsum  = 56'(hp_reg) + 56'(lp_reg[53:23]) + 56'(1 << 27);
    assign dfull = dsum[55:28];

    always_ff @(posedge clk)
    begin
        prod_reg <= 47'(radius_reg) * 47'(zc);
        hp_reg   <= 55'(prod_reg[46:23]) * 55'(PI_Q29);
        lp_reg   <= 54'(prod_reg[22:0]) * 54'(PI_Q29);
        dist_reg <= (dfull > 28'(DIST_MAX)) ? DIST_MAX : dfull[25:0];
    end

    assign done     = vld_reg[LATENCY-1];
    assign distance = dist_reg;

endmodule

// ----- hw/rtl/hvd_checker.sv -----
// Port-level checks for haversine_distance, attached by bind.
// Depends on hvd_pkg and haversine_distance.
`timescale 1ns / 1ps

module hvd_checker
    import hvd_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic        done,
    input logic [25:0] distance,
    input logic        cfg_valid,
    input logic        cfg_ready
);

    // every transfer is followed by a matching done strobe
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LATENCY done)
        else $error("missing result after input transfer");

    // no result without a matching input transfer
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LATENCY))
        else $error("result without input transfer");

    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (distance <= DIST_MAX))
        else $error("distance beyond saturation limit");

    a_cfg_taken: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("config write stalled");

endmodule

bind haversine_distance hvd_checker u_hvd_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .done      (done),
    .distance  (distance),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready)
);

// ----- tb/haversine_distance_test.sv -----
// Testbench for haversine_distance: random and directed point pairs against a bit-exact predictor.
// Depends on hvd_pkg and the haversine_distance RTL.
`timescale 1ns / 1ps

module haversine_distance_test;
    import hvd_pkg::*;

    // Holds the distances still due from the pipeline and counts mismatches.
    class distance_board;
        logic [25:0] pending[$];
        int          errors;
        int          checked;

        function void note_pair(logic [25:0] want);
            pending.push_back(want);
        endfunction

        function void check_distance(logic [25:0] got);
            logic [25:0] want;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected distance %0d", $time, got);
                errors++;
                return;
            end
            want = pending.pop_front();
            checked++;
            if (want !== got)
            begin
                $display("%0t: distance expected %0d actual %0d", $time, want, got);
                errors++;
            end
        endfunction
    endclass

    localparam longint LAT_LIM = 5898240;
    localparam longint LON_LIM = 11796480;
    localparam int     DRAIN   = LATENCY + 20;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic signed [23:0] first_latitude;
    logic signed [23:0] second_latitude;
    logic signed [24:0] first_longitude;
    logic signed [24:0] second_longitude;
    logic               done;
    logic [25:0]        distance;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [15:0]        cfg_data;

    distance_board board;
    logic [15:0]   radius_km;   // predictor copy of the radius register
    longint        cycles;
    int            sent;

    haversine_distance uut (
        .clk              (clk),
        .rst_n            (rst_n),
        .start            (start),
        .busy             (busy),
        .first_latitude   (first_latitude),
        .second_latitude  (second_latitude),
        .first_longitude  (first_longitude),
        .second_longitude (second_longitude),
        .done             (done),
        .distance         (distance),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_data         (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // Watchdog: far above the slowest legal run.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > 400000)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Results cannot be held off, so every strobe is checked on the edge that ends it.
    always @(posedge clk)
    begin
        if (rst_n && done)
            board.check_distance(distance);
    end

    // ---------------- predictor ----------------

    function automatic longint floor_shift(longint v, int s);
        return v >>> s;   // arithmetic shift rounds toward minus infinity
    endfunction

    function automatic longint limit(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    // Fixed-point degrees to binary angle; halves round away from zero.
    function automatic logic [31:0] degrees_to_turns(longint d, longint div);
        longint mag;
        longint q;
        mag = (d < 0 ? -d : d) << 16;
        q = (mag + div / 2) / div;
        if (d < 0)
            q = -q;
        return q[31:0];
    endfunction

    // Rotation CORDIC; quadrants beyond a quarter turn are folded by half a turn.
    task automatic rotate_unit(input logic [31:0] ang, output longint s, output longint c);
        longint x;
        longint y;
        longint z;
        longint nx;
        bit     flip;
        x = 652032874;
        y = 0;
        flip = 0;
        if (ang >= 32'h40000000 && ang < 32'hC0000000)
        begin
            ang = ang - 32'h80000000;
            flip = 1;
        end
        z = longint'(signed'(ang));
        for (int i = 0; i < ANGLE_STEPS; i++)
        begin
            if (z >= 0)
            begin
                nx = x - floor_shift(y, i);
                y = y + floor_shift(x, i);
                z = z - longint'(ATAN_TABLE[i]);
            end
            else
            begin
                nx = x + floor_shift(y, i);
                y = y - floor_shift(x, i);
                z = z + longint'(ATAN_TABLE[i]);
            end
            x = nx;
        end
        if (flip)
        begin
            x = -x;
            y = -y;
        end
        c = limit(x, -(64'sd1 <<< 30), 64'sd1 <<< 30);
        s = limit(y, -(64'sd1 <<< 30), 64'sd1 <<< 30);
    endtask

    function automatic longint floor_root(longint v);
        longint r;
        longint b;
        r = 0;
        b = 64'sd1 <<< 62;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    // Vectoring CORDIC: half central angle as a binary angle, clamped to a quarter turn.
    function automatic logic [31:0] half_angle(longint x, longint y);
        logic [31:0] z;
        longint      nx;
        z = 0;
        for (int i = 0; i < ANGLE_STEPS; i++)
        begin
            if (y >= 0)
            begin
                nx = x + floor_shift(y, i);
                y = y - floor_shift(x, i);
                z = z + ATAN_TABLE[i];
            end
            else
            begin
                nx = x - floor_shift(y, i);
                y = y + floor_shift(x, i);
                z = z - ATAN_TABLE[i];
            end
            x = nx;
        end
        if (z[31])
            return 32'd0;
        if (z > 32'h40000000)
            return 32'h40000000;
        return z;
    endfunction

    task automatic predict_distance(input longint lat1, input longint lat2,
                                    input longint lon1, input longint lon2,
                                    output logic [25:0] predicted);
        longint     s1;
        longint     s2;
        longint     c1;
        longint     c2;
        longint     unused;
        longint     p30;
        longint     a;
        longint     yq;
        longint     xq;
        logic [31:0] z;
        logic [63:0] prod;
        logic [63:0] hi;
        logic [63:0] lo;
        logic [63:0] d;
        rotate_unit(degrees_to_turns(lat2 - lat1, 720), s1, unused);
        rotate_unit(degrees_to_turns(lon2 - lon1, 720), s2, unused);
        rotate_unit(degrees_to_turns(lat1, 360), unused, c1);
        rotate_unit(degrees_to_turns(lat2, 360), unused, c2);
        p30 = floor_shift(c1 * c2, 30);
        a = s1 * s1 + floor_shift(p30 * s2, 30) * s2;
        a = limit(a, 0, 64'sd1 <<< 60);
        yq = floor_root(a);
        xq = floor_root((64'sd1 <<< 60) - a);
        z = half_angle(xq <<< 16, yq <<< 16);
        prod = 64'(radius_km) * 64'(z);
        hi = prod >> 23;
        lo = prod & ((64'd1 << 23) - 1);
        d = (hi * 64'(PI_Q29) + ((lo * 64'(PI_Q29)) >> 23) + (64'd1 << 27)) >> 28;
        if (d > 64'(DIST_MAX))
            d = 64'(DIST_MAX);
        predicted = d[25:0];
    endtask

    // ---------------- drivers ----------------

    // One start transfer; busy is sampled at the edge that takes the pair.
    task automatic send_pair(input longint lat1, input longint lat2,
                             input longint lon1, input longint lon2);
        logic [25:0] want;
        first_latitude   <= lat1[23:0];
        second_latitude  <= lat2[23:0];
        first_longitude  <= lon1[24:0];
        second_longitude <= lon2[24:0];
        start            <= 1'b1;
        do
            @(posedge clk);
        while (busy);
        predict_distance(longint'(signed'(lat1[23:0])), longint'(signed'(lat2[23:0])),
                         longint'(signed'(lon1[24:0])), longint'(signed'(lon2[24:0])), want);
        board.note_pair(want);
        sent++;
    endtask

    task automatic pause_sender(input int n);
        start <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    // Let every pending result come back, plus pipeline depth, before a register write.
    task automatic drain;
        start <= 1'b0;
        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (DRAIN) @(posedge clk);
    endtask

    task automatic write_radius(input logic [15:0] r);
        cfg_data  <= r;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        radius_km = r;
    endtask

    function automatic longint pick(longint lim);
        // mostly in range, sometimes the extremes, now and then any bit pattern
        int sel;
        sel = $urandom_range(0, 15);
        if (sel == 0)
            return lim;
        if (sel == 1)
            return -lim;
        if (sel == 2)
            return longint'($urandom()) - 64'sd2147483648;   // raw bits, wraps at port width
        return longint'($urandom_range(0, 2 * lim)) - lim;
    endfunction

    // Random bursts; close pairs are frequent so small distances get exercised too.
    task automatic random_phase(input int count);
        longint la;
        longint lb;
        longint oa;
        longint ob;
        for (int k = 0; k < count; k++)
        begin
            la = pick(LAT_LIM);
            oa = pick(LON_LIM);
            if ($urandom_range(0, 3) == 0)
            begin
                lb = limit(la + longint'($urandom_range(0, 20000)) - 10000,
                           -LAT_LIM, LAT_LIM);
                ob = limit(oa + longint'($urandom_range(0, 20000)) - 10000,
                           -LON_LIM, LON_LIM);
            end
            else
            begin
                lb = pick(LAT_LIM);
                ob = pick(LON_LIM);
            end
            send_pair(la, lb, oa, ob);
            // burst ends at random; some long stretches without gaps
            if ($urandom_range(0, 5) == 0)
                pause_sender($urandom_range(1, 12));
        end
        start <= 1'b0;
    endtask

    initial
    begin
        logic [15:0] radii[6];
        board      = new();
        cycles     = 0;
        sent       = 0;
        rst_n      = 1'b0;
        start      = 1'b0;
        cfg_valid  = 1'b0;
        cfg_data   = '0;
        first_latitude   = '0;
        second_latitude  = '0;
        first_longitude  = '0;
        second_longitude = '0;
        radius_km  = RADIUS_RESET;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: identical points, antipodes, poles, range extremes, wrapping inputs.
        send_pair(0, 0, 0, 0);
        send_pair(LAT_LIM, -LAT_LIM, 0, 0);
        send_pair(0, 0, -LON_LIM, LON_LIM);
        send_pair(0, 0, 0, LON_LIM);
        send_pair(LAT_LIM, LAT_LIM, -LON_LIM, LON_LIM);
        send_pair(-LAT_LIM, LAT_LIM, -LON_LIM, LON_LIM);
        send_pair(LAT_LIM, -LAT_LIM, LON_LIM, -LON_LIM);
        send_pair(1, 0, 0, 0);
        send_pair(0, 0, 0, 1);
        send_pair(-1, -1, -1, 1);
        send_pair(2949120, 2949121, 5898240, 5898240);
        send_pair(-8388608, 8388607, -16777216, 16777215);   // beyond the range, full bits
        send_pair(8388607, -8388608, 16777215, -16777216);
        send_pair(-8388608, -8388608, 0, 16777215);
        pause_sender(3);
        send_pair(3276800, -2457600, 1234567, -7654321);
        random_phase(300);

        // Radius sweep including zero, one and full scale; the last restores the default.
        radii = '{16'd0, 16'd1, 16'hFFFF, 16'd40000, 16'd777, RADIUS_RESET};
        foreach (radii[i])
        begin
            drain();
            write_radius(radii[i]);
            if (radii[i] == 16'hFFFF)
            begin
                send_pair(LAT_LIM, -LAT_LIM, 0, 0);   // saturates at full radius
                send_pair(0, 0, -LON_LIM, LON_LIM);
            end
            random_phase(i == 0 ? 100 : 280);
        end

        drain();
        $display("Sent %0d point pairs over six radius settings; %0d distances compared.",
                 sent, board.checked);
        if (board.errors == 0 && board.pending.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
